[hw/rtl/bsq_pkg.sv]
// Package for the balanced shift queue pair.
// Holds the command/result beat structs, the cell control and cell state structs,
// and the opcode and fill byte constants. Depends on nothing.
`default_nettype none

package bsq_pkg;

    localparam logic       OP_ENQUEUE = 1'b0;
    localparam logic       OP_DEQUEUE = 1'b1;
    localparam logic [7:0] FILL_BYTE  = 8'd35;   // '#'

    typedef struct packed {
        logic       opcode;
        logic [7:0] write_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       done_ok;
        logic       went_to_second;
        logic [3:0] first_length;
        logic [3:0] second_length;
    } t_result;

    // Broadcast to every cell in a cycle.
    typedef struct packed {
        logic       pop_first;
        logic       pop_second;
        logic       push_first;
        logic       push_second;
        logic [7:0] write_byte;
    } t_cell_ctl;

    // What one cell holds and shows its neighbours.
    typedef struct packed {
        logic       occ_first;
        logic       occ_second;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
    } t_cell_state;

endpackage

`default_nettype wire

[hw/rtl/balanced_shift_queue_pair_top.sv]
// Balanced shift queue pair: each accepted command gives its o_done beat in the next cycle.
// Throughput 1 command per cycle: every cell shifts or loads in the same cycle; busy stays low.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
// Synchronous active-low reset empties both queues (counts to zero, cell occupancy clear).
// Depends on bsq_pkg and bsq_cell.
`default_nettype none

module balanced_shift_queue_pair_top
    import bsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_cmd    i_cmd,
    output logic         o_done,
    output t_result      o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Element counts; the cells carry a thermometer copy of the same figure.
    logic [CNT_W-1:0] r_first_cnt,  n_first_cnt;
    logic [CNT_W-1:0] r_second_cnt, n_second_cnt;
    logic             r_done;
    t_result          r_result, n_result;

    t_cell_ctl        w_ctl;
    t_cell_state      w_cell  [QUEUE_DEPTH];
    t_cell_state      w_right [QUEUE_DEPTH];
    logic             w_left_first  [QUEUE_DEPTH];
    logic             w_left_second [QUEUE_DEPTH];

    logic w_accept, w_enq, w_both_full, w_any, w_first_ge;
    logic [CNT_W+3:0] w_first_ext, w_second_ext;

    // Never stall the command side: every cycle has room for a new beat.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_enq    = (i_cmd.opcode == OP_ENQUEUE);

    assign w_both_full = (r_first_cnt == DEPTH_CNT) && (r_second_cnt == DEPTH_CNT);
    assign w_any       = (r_first_cnt != '0) || (r_second_cnt != '0);
    // Ties send an enqueue to the second queue and a dequeue to the first.
    assign w_first_ge  = (r_first_cnt >= r_second_cnt);

    always_comb begin
        w_ctl.write_byte  = i_cmd.write_byte;
        w_ctl.push_second = w_accept && w_enq && !w_both_full && w_first_ge;
        w_ctl.push_first  = w_accept && w_enq && !w_both_full && !w_first_ge;
        w_ctl.pop_first   = w_accept && !w_enq && w_any && w_first_ge;
        w_ctl.pop_second  = w_accept && !w_enq && w_any && !w_first_ge;
    end

    // Advance the counts alongside the cells.
    always_comb begin
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        if (w_ctl.push_first)  n_first_cnt  = r_first_cnt + ONE_CNT;
        if (w_ctl.pop_first)   n_first_cnt  = r_first_cnt - ONE_CNT;
        if (w_ctl.push_second) n_second_cnt = r_second_cnt + ONE_CNT;
        if (w_ctl.pop_second)  n_second_cnt = r_second_cnt - ONE_CNT;
    end

    assign w_first_ext  = {4'b0000, n_first_cnt};
    assign w_second_ext = {4'b0000, n_second_cnt};

    // Build the result beat: the head is always cell 0; report the low four count bits.
    always_comb begin
        n_result.read_byte = FILL_BYTE;
        if (w_ctl.pop_first)  n_result.read_byte = w_cell[0].byte_first;
        if (w_ctl.pop_second) n_result.read_byte = w_cell[0].byte_second;
        n_result.done_ok        = w_ctl.push_first || w_ctl.push_second ||
                                  w_ctl.pop_first  || w_ctl.pop_second;
        n_result.went_to_second = w_ctl.push_second || w_ctl.pop_second;
        n_result.first_length   = w_first_ext[3:0];
        n_result.second_length  = w_second_ext[3:0];
    end

    // The chain: each cell sees its left neighbour's occupancy and its right neighbour's entry.
    // Past the tail a dequeue shifts in an empty fill entry; ahead of the head counts as full.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right[g] = '{occ_first: 1'b0, occ_second: 1'b0,
                                  byte_first: FILL_BYTE, byte_second: FILL_BYTE};
        end else begin : g_mid
            assign w_right[g] = w_cell[g+1];
        end
        if (g == 0) begin : g_head
            assign w_left_first[g]  = 1'b1;
            assign w_left_second[g] = 1'b1;
        end else begin : g_body
            assign w_left_first[g]  = w_cell[g-1].occ_first;
            assign w_left_second[g] = w_cell[g-1].occ_second;
        end

        bsq_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctl            (w_ctl),
            .i_left_occ_first (w_left_first[g]),
            .i_left_occ_second(w_left_second[g]),
            .i_right          (w_right[g]),
            .o_state          (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_done       <= 1'b0;
        end else begin
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
            r_done       <= w_accept;
        end
    end

    // Hold the result beat as payload; the strobe alone carries its validity.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted command yields exactly one result beat in the next cycle.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted command produced no result beat");

    // The head cell's first-queue occupancy must agree with the first counter.
    a_head_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[0].occ_first == (r_first_cnt != '0))
        else $error("first queue head occupancy disagrees with count");

    // Balancing keeps the second queue equal to, or one longer than, the first.
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second_cnt == r_first_cnt) ||
        ({1'b0, r_second_cnt} == ({1'b0, r_first_cnt} + {1'b0, ONE_CNT})))
        else $error("queue lengths out of balance");

endmodule

`default_nettype wire

[hw/rtl/bsq_cell.sv]
// One cell of the queue pair: entry i of the first and of the second queue.
// Depends on bsq_pkg (t_cell_ctl, t_cell_state).
`default_nettype none

module bsq_cell
    import bsq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic        i_left_occ_first,
    input  wire logic        i_left_occ_second,
    input  wire t_cell_state i_right,
    output t_cell_state      o_state
);

    logic       r_occ_first,  n_occ_first;
    logic       r_occ_second, n_occ_second;
    logic [7:0] r_byte_first, n_byte_first;
    logic [7:0] r_byte_second, n_byte_second;

    // Pop: take the right neighbour's entry. Push: load only at the first free cell.
    always_comb begin
        n_occ_first  = r_occ_first;
        n_byte_first = r_byte_first;
        if (i_ctl.pop_first) begin
            n_occ_first  = i_right.occ_first;
            n_byte_first = i_right.byte_first;
        end else if (i_ctl.push_first && !r_occ_first && i_left_occ_first) begin
            n_occ_first  = 1'b1;
            n_byte_first = i_ctl.write_byte;
        end
    end

    always_comb begin
        n_occ_second  = r_occ_second;
        n_byte_second = r_byte_second;
        if (i_ctl.pop_second) begin
            n_occ_second  = i_right.occ_second;
            n_byte_second = i_right.byte_second;
        end else if (i_ctl.push_second && !r_occ_second && i_left_occ_second) begin
            n_occ_second  = 1'b1;
            n_byte_second = i_ctl.write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_first  <= 1'b0;
            r_occ_second <= 1'b0;
        end else begin
            r_occ_first  <= n_occ_first;
            r_occ_second <= n_occ_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte_first  <= n_byte_first;
        r_byte_second <= n_byte_second;
    end

    assign o_state.occ_first   = r_occ_first;
    assign o_state.occ_second  = r_occ_second;
    assign o_state.byte_first  = r_byte_first;
    assign o_state.byte_second = r_byte_second;

endmodule

`default_nettype wire

[tb/sv/balanced_shift_queue_pair_checker.sv]
// Checker for the balanced shift queue pair: predicts each result beat and compares it.
// Watches the command and result channels beside the block. Depends on bsq_pkg.
module balanced_shift_queue_pair_checker
    import bsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_busy,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_done,
    input  wire t_result i_result,
    output int           o_pending,
    output int           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted contents of the two queues, head at index 0.
    logic [7:0] first_bytes[$];
    logic [7:0] second_bytes[$];
    t_result    expected_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // Apply one command to the predicted queues and return the result it gives.
    function automatic t_result apply_queue_op(input t_cmd cmd);
        t_result res;
        int      n_first;
        int      n_second;
        res.read_byte      = FILL_BYTE;
        res.done_ok        = 1'b0;
        res.went_to_second = 1'b0;
        if (cmd.opcode == OP_ENQUEUE) begin
            if (!(first_bytes.size() >= QUEUE_DEPTH && second_bytes.size() >= QUEUE_DEPTH)) begin
                if (first_bytes.size() >= second_bytes.size()) begin
                    second_bytes.push_back(cmd.write_byte);
                    res.went_to_second = 1'b1;
                end else begin
                    first_bytes.push_back(cmd.write_byte);
                end
                res.done_ok = 1'b1;
            end
        end else if (first_bytes.size() != 0 || second_bytes.size() != 0) begin
            if (first_bytes.size() >= second_bytes.size()) begin
                res.read_byte = first_bytes.pop_front();
            end else begin
                res.read_byte      = second_bytes.pop_front();
                res.went_to_second = 1'b1;
            end
            res.done_ok = 1'b1;
        end
        n_first            = first_bytes.size();
        n_second           = second_bytes.size();
        res.first_length   = n_first[3:0];
        res.second_length  = n_second[3:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            first_bytes.delete();
            second_bytes.delete();
            expected_results.delete();
        end else begin
            // Queue the expectation first so a result in the same cycle still finds it.
            if (i_start && !i_busy) begin
                expected_results.push_back(apply_queue_op(i_cmd));
            end
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", i_result.read_byte, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.read_byte !== want.read_byte)
                        report_mismatch("read_byte", i_result.read_byte, want.read_byte);
                    if (i_result.done_ok !== want.done_ok)
                        report_mismatch("done_ok", i_result.done_ok, want.done_ok);
                    if (i_result.went_to_second !== want.went_to_second)
                        report_mismatch("went_to_second", i_result.went_to_second,
                                        want.went_to_second);
                    if (i_result.first_length !== want.first_length)
                        report_mismatch("first_length", i_result.first_length,
                                        want.first_length);
                    if (i_result.second_length !== want.second_length)
                        report_mismatch("second_length", i_result.second_length,
                                        want.second_length);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/sv/balanced_shift_queue_pair_top_test.sv]
// Top of the testbench for the balanced shift queue pair: clock, reset, command stimulus, verdict.
// Depends on bsq_pkg, balanced_shift_queue_pair_top and balanced_shift_queue_pair_checker.
module balanced_shift_queue_pair_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int TARGET_BEATS = 1200;

    logic    clk;
    logic    rst_n;
    logic    start;
    t_cmd    cmd;
    logic    busy;
    logic    done;
    t_result result;
    int      pending;
    int      errors;
    int      beats_sent;

    balanced_shift_queue_pair_top #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_done   (done),
        .o_result (result)
    );

    // The checker sees exactly what the block sees and keeps its own copy of both queues.
    balanced_shift_queue_pair_checker #(
        .QUEUE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (cmd),
        .i_done    (done),
        .i_result  (result),
        .o_pending (pending),
        .o_errors  (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one command beat at the falling edge and hold it until the block takes it.
    // Start stays high afterwards so that back-to-back beats run without a gap.
    task automatic issue_command(input logic op, input logic [7:0] data);
        @(negedge clk);
        start           <= 1'b1;
        cmd.opcode      <= op;
        cmd.write_byte  <= data;
        do @(posedge clk); while (busy);
        beats_sent++;
    endtask

    // Drop start for a number of cycles; scribble on the idle command to show it is ignored.
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            start          <= 1'b0;
            cmd.opcode     <= 1'($urandom_range(0, 1));
            cmd.write_byte <= 8'($urandom_range(0, 255));
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Hold off until every predicted result beat has come back.
    task automatic drain_results();
        idle_gap(1);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int burst_len;
        int deq_weight;
        int gap;
        logic op;
        logic [7:0] data;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        beats_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Dequeue from two empty queues: expect the fill byte and no success.
        issue_command(OP_DEQUEUE, 8'h00);
        // Fill both queues to the brim, alternating between them, with edge values among the data.
        issue_command(OP_ENQUEUE, 8'h00);
        issue_command(OP_ENQUEUE, 8'hFF);
        issue_command(OP_ENQUEUE, FILL_BYTE);
        issue_command(OP_ENQUEUE, 8'h01);
        issue_command(OP_ENQUEUE, 8'h80);
        issue_command(OP_ENQUEUE, 8'h7F);
        issue_command(OP_ENQUEUE, 8'hAA);
        issue_command(OP_ENQUEUE, 8'h55);
        idle_gap(3);
        repeat (2 * DEPTH - 8) issue_command(OP_ENQUEUE, 8'($urandom_range(0, 255)));
        // Both queues now full: this byte must be dropped.
        issue_command(OP_ENQUEUE, 8'hFF);
        // Take a few heads back out, equal lengths first so the first queue gives way.
        repeat (6) issue_command(OP_DEQUEUE, 8'($urandom_range(0, 255)));

        // Pause until every outstanding beat has returned before the random part.
        drain_results();

        // Random part: bursts that lean towards enqueue or dequeue, so the pair swings
        // between empty and full over and over, with random gaps between bursts.
        while (beats_sent < TARGET_BEATS) begin
            burst_len = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: begin
                    deq_weight = 2;
                end
                1: begin
                    deq_weight = 8;
                end
                default: begin
                    deq_weight = 5;
                end
            endcase
            repeat (burst_len) begin
                op   = ($urandom_range(0, 9) < deq_weight) ? OP_DEQUEUE : OP_ENQUEUE;
                data = ($urandom_range(0, 15) == 0) ? FILL_BYTE : 8'($urandom_range(0, 255));
                issue_command(op, data);
            end
            // A third of the bursts run straight into the next one; the rest idle a while.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            idle_gap(gap);
            if (beats_sent >= TARGET_BEATS / 2 && beats_sent < TARGET_BEATS / 2 + 24) begin
                drain_results();
            end
        end

        // Wind down: wait for the last beats, then a few cycles for anything stray.
        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hang: report failure and stop if the run is still going at the time limit.
    initial begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

endmodule
